>>> rtl/core/mdsvs_pkg.sv
// mdsvs_pkg: shared types, opcodes and arithmetic helpers for the decaying-sine voice synth
// used by mdsvs_voice_cell and midi_decaying_sine_voice_synth; no dependencies

package mdsvs_pkg;

    // stream opcodes carried in s_tuser
    localparam logic OPC_TICK = 1'b0;
    localparam logic OPC_MIDI = 1'b1;

    // midi status nibbles and controller numbers
    localparam logic [3:0] NIB_NOTE_OFF   = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON    = 4'h9;
    localparam logic [3:0] NIB_CONTROLLER = 4'hB;
    localparam logic [6:0] CC_ALL_SOUND_OFF = 7'd120;
    localparam logic [6:0] CC_ALL_NOTES_OFF = 7'd123;

    // configuration register indexes
    localparam logic [1:0] REG_HOLD_DECAY    = 2'd0;
    localparam logic [1:0] REG_RELEASE_DECAY = 2'd1;
    localparam logic [1:0] REG_ALL_DECAY     = 2'd2;
    localparam logic [1:0] REG_THRESHOLD     = 2'd3;

    localparam logic [23:0] RST_HOLD_DECAY    = 24'd16776209;
    localparam logic [23:0] RST_RELEASE_DECAY = 24'd16760439;
    localparam logic [23:0] RST_ALL_DECAY     = 24'd16693330;
    localparam logic [23:0] RST_THRESHOLD     = 24'd3355;

    // voice cell operations
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_Z2        = 4'd1;
    localparam logic [3:0] OP_P1        = 4'd2;
    localparam logic [3:0] OP_P2        = 4'd3;
    localparam logic [3:0] OP_P3        = 4'd4;
    localparam logic [3:0] OP_S         = 4'd5;
    localparam logic [3:0] OP_MIX       = 4'd6;
    localparam logic [3:0] OP_DECAY     = 4'd7;
    localparam logic [3:0] OP_GATE      = 4'd8;
    localparam logic [3:0] OP_SCAN_LOAD = 4'd9;
    localparam logic [3:0] OP_SHIFT     = 4'd10;
    localparam logic [3:0] OP_START     = 4'd11;
    localparam logic [3:0] OP_RELEASE   = 4'd12;
    localparam logic [3:0] OP_ALL_OFF   = 4'd13;

    // quarter-wave sine polynomial, Q1.30
    localparam logic [31:0] SIN_K4 = 32'd5026995;
    localparam logic [31:0] SIN_C3 = 32'd85569306;
    localparam logic [31:0] SIN_C2 = 32'd693598669;
    localparam logic [31:0] SIN_C1 = 32'd1686629713;

    // signed contribution of one voice and the mix accumulator
    localparam int CONTRIB_W = 42;
    localparam int ACC_W     = 47;

    // top octave phase increments at 32 kHz, Q0.32
    localparam logic [31:0] OCT_TOP [12] = '{
        32'd1123673247, 32'd1190490336, 32'd1261280574, 32'd1336280220,
        32'd1415739577, 32'd1499923833, 32'd1589113944, 32'd1683607578,
        32'd1783720094, 32'd1889785611, 32'd2002158110, 32'd2121212627
    };

    typedef struct packed {
        logic [23:0] hold_decay;
        logic [23:0] release_decay;
        logic [23:0] all_notes_decay;
        logic [23:0] silence_threshold;
    } mdsvs_cfg_t;

    typedef struct packed {
        logic [3:0]  op;
        logic [6:0]  key;
        logic [23:0] amp;
    } mdsvs_cmd_t;

    // phase increment of a key, rounded, for a phase word of pb bits
    function automatic logic [31:0] key_inc(input logic [6:0] key, input int pb);
        logic [3:0]  oct;
        logic [6:0]  semi;
        logic [32:0] v;
        int          s;
        oct = 4'd0;
        for (int i = 1; i <= 10; i++) begin
            if (key >= 7'(12 * i)) begin
                oct = oct + 4'd1;
            end
        end
        semi = key - ((7'(oct) << 3) + (7'(oct) << 2));
        v = {1'b0, OCT_TOP[semi[3:0]]};
        s = (10 - int'(oct)) + (32 - pb);
        if (s == 0) begin
            return v[31:0];
        end
        return 32'((v + (33'd1 << (s - 1))) >> s);
    endfunction

    // floor(vel * 2^22 / 127): vel * 33026 leaves a remainder of 2 * vel
    function automatic logic [23:0] note_amp(input logic [6:0] vel);
        logic [22:0] base;
        logic [7:0]  rem;
        base = 23'(vel) * 23'd33026;
        rem  = {vel, 1'b0};
        if (rem >= 8'd254) begin
            return 24'(base) + 24'd2;
        end else if (rem >= 8'd127) begin
            return 24'(base) + 24'd1;
        end
        return 24'(base);
    endfunction

endpackage

>>> rtl/core/mdsvs_voice_cell.sv
// mdsvs_voice_cell: one synth voice with its own time-shared multiplier
// and a link register shifted toward cell 0; depends on mdsvs_pkg

module mdsvs_voice_cell #(
    parameter int PHASE_BITS = 24,
    parameter int TABLE_BITS = 10
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  mdsvs_pkg::mdsvs_cmd_t                cmd,
    input  mdsvs_pkg::mdsvs_cfg_t                cfg,
    input  logic                                 sel,
    input  logic signed [mdsvs_pkg::CONTRIB_W-1:0] link_in,
    output logic signed [mdsvs_pkg::CONTRIB_W-1:0] link_out,
    output logic                                 active
);
    import mdsvs_pkg::*;

    logic                        active_reg;
    logic [6:0]                  key_reg;
    logic [PHASE_BITS-1:0]       phase_reg;
    logic [23:0]                 amp_reg;
    logic [23:0]                 decay_reg;
    logic [30:0]                 z2_reg;
    logic [30:0]                 p_reg;
    logic [16:0]                 r_reg;
    logic signed [CONTRIB_W-1:0] link_reg;

    logic [TABLE_BITS-1:0]       idx;
    logic [29:0]                 zlow;
    logic [30:0]                 z;
    logic [30:0]                 mul_a;
    logic [30:0]                 mul_b;
    logic [61:0]                 prod;
    logic [31:0]                 shr30;
    logic [32:0]                 s_round;
    logic signed [CONTRIB_W-1:0] mag;
    logic [31:0]                 inc_full;
    logic [PHASE_BITS-1:0]       phase_next;

    // table step of the phase, folded into the first quadrant
    assign idx  = phase_reg[PHASE_BITS-1 -: TABLE_BITS];
    assign zlow = {idx[TABLE_BITS-3:0], {(32-TABLE_BITS){1'b0}}};
    assign z    = idx[TABLE_BITS-2] ? ((31'd1 << 30) - {1'b0, zlow}) : {1'b0, zlow};

    always_comb begin
        unique case (cmd.op) inside
            OP_Z2: begin
                mul_a = z;
                mul_b = z;
            end
            OP_P1: begin
                mul_a = SIN_K4[30:0];
                mul_b = z2_reg;
            end
            OP_P2, OP_P3: begin
                mul_a = p_reg;
                mul_b = z2_reg;
            end
            OP_S: begin
                mul_a = z;
                mul_b = p_reg;
            end
            OP_MIX: begin
                mul_a = 31'(amp_reg);
                mul_b = 31'(r_reg);
            end
            OP_DECAY: begin
                mul_a = 31'(amp_reg);
                mul_b = 31'(decay_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod    = 62'(mul_a) * 62'(mul_b);
    assign shr30   = prod[61:30];
    assign s_round = {1'b0, shr30} + 33'd16384;
    assign mag     = signed'({1'b0, prod[CONTRIB_W-2:0]});

    assign inc_full   = key_inc(key_reg, PHASE_BITS);
    assign phase_next = phase_reg + inc_full[PHASE_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else begin
            unique case (cmd.op)
                OP_GATE: begin
                    if (active_reg && (amp_reg < cfg.silence_threshold)) begin
                        active_reg <= 1'b0;
                    end
                end
                OP_START: begin
                    if (sel) begin
                        active_reg <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_Z2: z2_reg <= shr30[30:0];
            OP_P1: p_reg  <= 31'(SIN_C3 - shr30);
            OP_P2: p_reg  <= 31'(SIN_C2 - shr30);
            OP_P3: p_reg  <= 31'(SIN_C1 - shr30);
            OP_S:  r_reg  <= s_round[31:15];
            OP_MIX: begin
                if (!active_reg) begin
                    link_reg <= '0;
                end else if (idx[TABLE_BITS-1]) begin
                    link_reg <= -mag;
                end else begin
                    link_reg <= mag;
                end
            end
            OP_DECAY: begin
                if (active_reg) begin
                    amp_reg   <= prod[47:24];
                    phase_reg <= phase_next;
                end
            end
            OP_SCAN_LOAD: begin
                // inactive voices rank below every active one
                link_reg <= active_reg ? CONTRIB_W'({1'b1, amp_reg}) : '0;
            end
            OP_SHIFT: link_reg <= link_in;
            OP_START: begin
                if (sel) begin
                    key_reg   <= cmd.key;
                    phase_reg <= '0;
                    amp_reg   <= cmd.amp;
                    decay_reg <= cfg.hold_decay;
                end
            end
            OP_RELEASE: begin
                if (active_reg && (key_reg == cmd.key)) begin
                    decay_reg <= cfg.release_decay;
                end
            end
            OP_ALL_OFF: decay_reg <= cfg.all_notes_decay;
            default: begin
            end
        endcase
    end

    assign link_out = link_reg;
    assign active   = active_reg;

endmodule

>>> rtl/core/midi_decaying_sine_voice_synth.sv
// midi_decaying_sine_voice_synth: polyphonic decaying-sine synth, top level
// sequencer, mix accumulator and output register over a chain of mdsvs_voice_cell
// depends on mdsvs_pkg and mdsvs_voice_cell
//
//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    s_tuser opcode, s_tdata midi message
//  m_        out  m_tvalid/m_tready    m_tdata sample and voice mask
//  cfg_      in   cfg_wr_en            cfg_wr_index, cfg_wr_data
//
// a tick steps each cell's multiplier through eight steps, shifts the contributions
// down the chain into the accumulator, then loads the magnitude register and the
// output register; the input is held off until the result register is loaded
// a note-on runs the steal scan down the same chain before it starts the chosen voice;
// other messages return to idle after the decode step
// the result register holds while m_tready is low; the next tick waits at its
// last step until the register is free. reset deactivates the voices and loads
// the default config

module midi_decaying_sine_voice_synth #(
    parameter int VOICE_COUNT        = 8,
    parameter int SINE_TABLE_ENTRIES = 1024,
    parameter int PHASE_BITS         = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // status_byte[7:0], first_data[14:8], second_data[21:15]
    input  logic        s_tuser,   // opcode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // sample[15:0], active_mask[23:16]
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_index,
    input  logic [23:0] cfg_wr_data
);
    import mdsvs_pkg::*;

    localparam int TABLE_BITS = $clog2(SINE_TABLE_ENTRIES);
    localparam int IDX_W      = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int CNT_W      = $clog2(VOICE_COUNT + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MSG   = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_START = 3'd3;
    localparam logic [2:0] S_CALC  = 3'd4;
    localparam logic [2:0] S_SHIFT = 3'd5;
    localparam logic [2:0] S_ABS   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    logic [2:0]              step_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [7:0]              msg_status_reg;
    logic [6:0]              msg_d1_reg;
    logic [6:0]              msg_d2_reg;
    logic [7:0]              mask_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic                    neg_reg;
    logic [ACC_W-1:0]        mag_reg;
    logic [24:0]             best_key_reg;
    logic [IDX_W-1:0]        best_idx_reg;
    logic                    m_tvalid_reg;
    logic [23:0]             m_tdata_reg;
    mdsvs_cfg_t              cfg_reg;

    mdsvs_cmd_t              cmd;
    logic                    s_fire;
    logic                    last_cnt;
    logic                    out_free;
    logic                    is_note_on;
    logic                    is_release;
    logic                    is_all_off;
    logic [7:0]              mask_now;
    logic [VOICE_COUNT-1:0]  active_vec;
    logic [VOICE_COUNT-1:0]  sel_vec;
    logic signed [CONTRIB_W-1:0] link_vec [VOICE_COUNT];
    logic [ACC_W+14:0]       scaled;
    logic [22:0]             q;
    logic [15:0]             sample_next;

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign last_cnt = (cnt_reg == CNT_W'(VOICE_COUNT - 1));
    assign out_free = !m_tvalid_reg || m_tready;

    // message decode
    always_comb begin
        is_note_on = 1'b0;
        is_release = 1'b0;
        is_all_off = 1'b0;
        unique case (msg_status_reg[7:4])
            NIB_NOTE_ON: begin
                is_note_on = (msg_d2_reg != 7'd0);
                is_release = (msg_d2_reg == 7'd0);
            end
            NIB_NOTE_OFF: is_release = 1'b1;
            NIB_CONTROLLER: begin
                is_all_off = (msg_d1_reg == CC_ALL_SOUND_OFF) ||
                             (msg_d1_reg == CC_ALL_NOTES_OFF);
            end
            default: begin
            end
        endcase
    end

    // command broadcast to the cells
    always_comb begin
        cmd.key = msg_d1_reg;
        cmd.amp = note_amp(msg_d2_reg);
        cmd.op  = OP_NONE;
        unique case (state_reg) inside
            S_MSG: begin
                if (is_note_on) begin
                    cmd.op = OP_SCAN_LOAD;
                end else if (is_release) begin
                    cmd.op = OP_RELEASE;
                end else if (is_all_off) begin
                    cmd.op = OP_ALL_OFF;
                end
            end
            S_SCAN, S_SHIFT: cmd.op = OP_SHIFT;
            S_START: cmd.op = OP_START;
            S_CALC: begin
                unique case (step_reg)
                    3'd0: cmd.op = OP_Z2;
                    3'd1: cmd.op = OP_P1;
                    3'd2: cmd.op = OP_P2;
                    3'd3: cmd.op = OP_P3;
                    3'd4: cmd.op = OP_S;
                    3'd5: cmd.op = OP_MIX;
                    3'd6: cmd.op = OP_DECAY;
                    default: cmd.op = OP_GATE;
                endcase
            end
            default: begin
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < VOICE_COUNT; gi++) begin : g_cell
            logic signed [CONTRIB_W-1:0] link_in;
            if (gi == VOICE_COUNT - 1) begin : g_end
                assign link_in = '0;
            end else begin : g_mid
                assign link_in = link_vec[gi+1];
            end
            assign sel_vec[gi] = (best_idx_reg == IDX_W'(gi));
            mdsvs_voice_cell #(
                .PHASE_BITS (PHASE_BITS),
                .TABLE_BITS (TABLE_BITS)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cmd      (cmd),
                .cfg      (cfg_reg),
                .sel      (sel_vec[gi]),
                .link_in  (link_in),
                .link_out (link_vec[gi]),
                .active   (active_vec[gi])
            );
        end
        for (gi = 0; gi < 8; gi++) begin : g_mask
            if (gi < VOICE_COUNT) begin : g_on
                assign mask_now[gi] = active_vec[gi];
            end else begin : g_off
                assign mask_now[gi] = 1'b0;
            end
        end
    endgenerate

    // acc * 32767 >> 39, truncated toward zero, then saturated
    assign scaled = {mag_reg, 15'd0} - (ACC_W+15)'(mag_reg);
    assign q      = scaled[ACC_W+14:39];
    always_comb begin
        if (!neg_reg) begin
            sample_next = (q > 23'd32767) ? 16'h7FFF : q[15:0];
        end else begin
            sample_next = (q > 23'd32768) ? 16'h8000 : 16'(-q[15:0]);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    state_next = (s_tuser == OPC_TICK) ? S_CALC : S_MSG;
                end
            end
            S_MSG:   state_next = is_note_on ? S_SCAN : S_IDLE;
            S_SCAN:  state_next = last_cnt ? S_START : S_SCAN;
            S_START: state_next = S_IDLE;
            S_CALC:  state_next = (step_reg == 3'd7) ? S_SHIFT : S_CALC;
            S_SHIFT: state_next = last_cnt ? S_ABS : S_SHIFT;
            S_ABS:   state_next = S_OUT;
            S_OUT:   state_next = out_free ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            cfg_reg      <= '{RST_HOLD_DECAY, RST_RELEASE_DECAY, RST_ALL_DECAY, RST_THRESHOLD};
        end else begin
            state_reg <= state_next;
            if ((state_reg == S_OUT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_wr_index)
                    REG_HOLD_DECAY:    cfg_reg.hold_decay        <= cfg_wr_data;
                    REG_RELEASE_DECAY: cfg_reg.release_decay     <= cfg_wr_data;
                    REG_ALL_DECAY:     cfg_reg.all_notes_decay   <= cfg_wr_data;
                    REG_THRESHOLD:     cfg_reg.silence_threshold <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            msg_status_reg <= s_tdata[7:0];
            msg_d1_reg     <= s_tdata[14:8];
            msg_d2_reg     <= s_tdata[21:15];
            mask_reg       <= mask_now;
            acc_reg        <= '0;
            step_reg       <= 3'd0;
        end
        if (state_reg == S_CALC) begin
            step_reg <= step_reg + 3'd1;
        end
        if ((state_reg == S_MSG) || (state_reg == S_CALC)) begin
            cnt_reg <= '0;
        end else if ((state_reg == S_SCAN) || (state_reg == S_SHIFT)) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        if (state_reg == S_SHIFT) begin
            acc_reg <= acc_reg + ACC_W'(link_vec[0]);
        end
        // steal scan: strict compare keeps the lowest index on ties
        if (state_reg == S_SCAN) begin
            if ((cnt_reg == '0) || (link_vec[0][24:0] < best_key_reg)) begin
                best_key_reg <= link_vec[0][24:0];
                best_idx_reg <= cnt_reg[IDX_W-1:0];
            end
        end
        if (state_reg == S_ABS) begin
            neg_reg <= acc_reg[ACC_W-1];
            mag_reg <= acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        end
        if ((state_reg == S_OUT) && out_free) begin
            m_tdata_reg <= {mask_reg, sample_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_result_from_out_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_OUT))
        else $error("result register loaded outside the output step");

    a_tick_starts_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == OPC_TICK)) |=> (state_reg == S_CALC))
        else $error("accepted tick did not start the voice computation");

    a_start_one_voice: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_START) |-> $onehot(sel_vec))
        else $error("note start does not select exactly one voice");

    a_no_result_for_message: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MSG) |=> !$rose(m_tvalid))
        else $error("midi message produced a result");

endmodule
